>>> hdl/gpse_pkg.sv
`default_nettype none
package gpse_pkg;

  localparam int EXP_DEPTH_DEF  = 256;
  localparam int ERFC_DEPTH_DEF = 256;

  localparam int CFG_IW = 3;
  localparam int CFG_DW = 32;

  // Q30 constants
  localparam longint LOG2E_Q30         = 64'sd1549082005;
  localparam longint LN2_Q30           = 64'sd744261118;
  localparam longint TWO_OVER_SQRTPI_Q30 = 64'sd1211587905;
  localparam longint ERFC_AT_FOUR_Q30  = 64'sd17;
  localparam logic signed [31:0] INV_SQRT2_Q30 = 32'sd759250125;

  // width of exp table entries: exp reaches e^16 in Q32; erfc is clamped to at most 2^31
  localparam int EXP_EW = 56;

  typedef enum logic [CFG_IW-1:0] {
    REG_GAUSS_AMP = 3'd0,
    REG_CENTROID  = 3'd1,
    REG_SIGMA     = 3'd2,
    REG_STEP_AMP  = 3'd3,
    REG_SLOPE     = 3'd4,
    REG_OFFSET    = 3'd5,
    REG_SKEW_AMP  = 3'd6,
    REG_BETA      = 3'd7
  } reg_idx_t;

  // reciprocal unit status and results
  typedef struct packed {
    logic        busy;
    logic [24:0] inv_s;
    logic [24:0] inv_b;
    logic [32:0] r;
  } recip_t;

  typedef struct packed {
    logic signed [47:0] v;
    logic               s;
  } term_t;

endpackage
`default_nettype wire

>>> hdl/gpse_recip.sv
`default_nettype none
module gpse_recip
  import gpse_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [15:0] sigma,
  input  wire logic [15:0] beta,
  output recip_t           rc
);

  typedef enum logic [3:0] {
    RS_IDLE  = 4'b0001,
    RS_DIV_S = 4'b0010,
    RS_DIV_B = 4'b0100,
    RS_MUL   = 4'b1000
  } rs_state_t;

  rs_state_t   state;
  logic [4:0]  cnt;
  logic [15:0] rem;
  logic [24:0] quo;
  logic [24:0] inv_s;
  logic [24:0] inv_b;
  logic [32:0] r;

  logic [15:0] sg;
  logic [15:0] bg;
  logic [15:0] dvs;
  logic [16:0] trial;
  logic        qb;
  logic [15:0] rem_next;
  logic [24:0] quo_next;
  logic [40:0] prod;

  assign sg  = (sigma == 16'd0) ? 16'd1 : sigma;
  assign bg  = (beta == 16'd0) ? 16'd1 : beta;
  assign dvs = (state == RS_DIV_S) ? sg : bg;

  // numerator is 2^24: its only set bit enters on the first step
  assign trial    = {rem, (cnt == 5'd0)};
  assign qb       = trial >= {1'b0, dvs};
  assign rem_next = qb ? 16'(trial - {1'b0, dvs}) : trial[15:0];
  assign quo_next = {quo[23:0], qb};
  assign prod     = {25'd0, sg} * {16'd0, inv_b};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= RS_IDLE;
      cnt   <= '0;
      rem   <= '0;
      quo   <= '0;
      inv_s <= 25'd65536;
      inv_b <= 25'd65536;
      r     <= 33'd65536;
    end else if (start) begin
      state <= RS_DIV_S;
      cnt   <= '0;
      rem   <= '0;
      quo   <= '0;
    end else begin
      case (state)
        RS_DIV_S, RS_DIV_B: begin
          if (cnt == 5'd24) begin
            cnt <= '0;
            rem <= '0;
            quo <= '0;
            if (state == RS_DIV_S) begin
              inv_s <= quo_next;
              state <= RS_DIV_B;
            end else begin
              inv_b <= quo_next;
              state <= RS_MUL;
            end
          end else begin
            rem <= rem_next;
            quo <= quo_next;
            cnt <= cnt + 5'd1;
          end
        end
        RS_MUL: begin
          r     <= prod[40:8];
          state <= RS_IDLE;
        end
        default: state <= RS_IDLE;
      endcase
    end
  end

  assign rc.busy  = (state != RS_IDLE);
  assign rc.inv_s = inv_s;
  assign rc.inv_b = inv_b;
  assign rc.r     = r;

  a_inv_floor: assert property (@(posedge clk) disable iff (rst)
    (inv_s >= 25'd256) && (inv_b >= 25'd256))
    else $error("reciprocal below its floor");

  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    start |=> rc.busy)
    else $error("reciprocal unit idle after restart");

  a_state_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot(state))
    else $error("reciprocal state not one-hot");

endmodule
`default_nettype wire

>>> hdl/gpse_lut.sv
`default_nettype none
module gpse_lut
  import gpse_pkg::*;
#(
  parameter int EXP_TABLE_DEPTH  = EXP_DEPTH_DEF,
  parameter int ERFC_TABLE_DEPTH = ERFC_DEPTH_DEF,
  parameter int EXP_DW  = $clog2(EXP_TABLE_DEPTH + 1),
  parameter int ERFC_DW = $clog2(ERFC_TABLE_DEPTH + 1)
) (
  input  wire logic [EXP_DW-1:0]  g_idx,
  input  wire logic [EXP_DW-1:0]  w_idx,
  input  wire logic [ERFC_DW-1:0] s_idx,
  input  wire logic [ERFC_DW-1:0] q_idx,
  output logic [EXP_EW-1:0]       g_lo,
  output logic [EXP_EW-1:0]       g_hi,
  output logic [EXP_EW-1:0]       w_lo,
  output logic [EXP_EW-1:0]       w_hi,
  output logic [31:0]             s_lo,
  output logic [31:0]             s_hi,
  output logic [31:0]             q_lo,
  output logic [31:0]             q_hi
);

  typedef logic [EXP_EW-1:0] exp_tab_t  [0:EXP_TABLE_DEPTH];
  typedef logic [31:0]       erfc_tab_t [0:ERFC_TABLE_DEPTH];

  // exp of a Q24 argument in Q32: 2^n times a series for the fraction
  function automatic logic [63:0] exp_core(input longint a_in);
    longint      a;
    longint      t;
    longint      n;
    longint      sh;
    logic [63:0] f;
    logic [63:0] rr;
    logic [63:0] term;
    logic [63:0] sum;
    a = a_in;
    if (a > (longint'(16) <<< 24)) a = longint'(16) <<< 24;
    if (a < -(longint'(16) <<< 24)) a = -(longint'(16) <<< 24);
    t = a * LOG2E_Q30;
    n = t >>> 54;
    f = (64'(t) & ((64'd1 << 54) - 64'd1)) >> 24;
    rr = (f * 64'(LN2_Q30)) >> 30;
    term = 64'd1 << 30;
    sum = term;
    for (int k = 1; k <= 16; k++) begin
      term = ((term * rr) >> 30) / 64'(k);
      sum = sum + term;
    end
    sh = n + 64'sd2;
    if (sh >= 0) return sum << sh;
    return sum >> (-sh);
  endfunction

  function automatic exp_tab_t build_exp();
    exp_tab_t tab;
    longint   a;
    for (int i = 0; i <= EXP_TABLE_DEPTH; i++) begin
      a = -(longint'(16) <<< 24) + (longint'(i) * (longint'(32) <<< 24)) / EXP_TABLE_DEPTH;
      tab[i] = EXP_EW'(exp_core(a));
    end
    return tab;
  endfunction

  // Simpson integration cell by cell, walking down from erfc(4)
  function automatic erfc_tab_t build_erfc();
    erfc_tab_t   tab;
    longint      a;
    longint      b;
    longint      t;
    logic [63:0] width;
    logic [63:0] sum;
    logic [63:0] integ;
    logic [63:0] inc;
    logic [63:0] v;
    logic [63:0] wt;
    tab[ERFC_TABLE_DEPTH] = 32'(ERFC_AT_FOUR_Q30);
    for (int i = ERFC_TABLE_DEPTH; i > 0; i--) begin
      a = -(longint'(4) <<< 24) + (longint'(i - 1) * (longint'(8) <<< 24)) / ERFC_TABLE_DEPTH;
      b = -(longint'(4) <<< 24) + (longint'(i) * (longint'(8) <<< 24)) / ERFC_TABLE_DEPTH;
      width = 64'(b - a);
      sum = '0;
      for (int k = 0; k <= 8; k++) begin
        t = a + longint'((width * 64'(k)) >> 3);
        if (k == 0 || k == 8) wt = 64'd1;
        else if (k % 2 == 1) wt = 64'd4;
        else wt = 64'd2;
        sum = sum + wt * exp_core(-longint'(64'(t * t) >> 24));
      end
      integ = (sum * width) / 64'd24;
      inc = ((integ >> 26) * 64'(TWO_OVER_SQRTPI_Q30)) >> 30;
      v = {32'd0, tab[i]} + inc;
      if (v > (64'd2 << 30)) v = 64'd2 << 30;
      tab[i - 1] = v[31:0];
    end
    return tab;
  endfunction

  localparam exp_tab_t  EXP_TAB  = build_exp();
  localparam erfc_tab_t ERFC_TAB = build_erfc();

  localparam logic [EXP_DW-1:0]  EXP_LAST  = EXP_DW'(EXP_TABLE_DEPTH);
  localparam logic [ERFC_DW-1:0] ERFC_LAST = ERFC_DW'(ERFC_TABLE_DEPTH);

  // at the top edge the upper neighbor repeats the last entry
  logic [EXP_DW-1:0]  g_nx;
  logic [EXP_DW-1:0]  w_nx;
  logic [ERFC_DW-1:0] s_nx;
  logic [ERFC_DW-1:0] q_nx;

  assign g_nx = (g_idx >= EXP_LAST) ? EXP_LAST : g_idx + 1'b1;
  assign w_nx = (w_idx >= EXP_LAST) ? EXP_LAST : w_idx + 1'b1;
  assign s_nx = (s_idx >= ERFC_LAST) ? ERFC_LAST : s_idx + 1'b1;
  assign q_nx = (q_idx >= ERFC_LAST) ? ERFC_LAST : q_idx + 1'b1;

  assign g_lo = EXP_TAB[g_idx];
  assign g_hi = EXP_TAB[g_nx];
  assign w_lo = EXP_TAB[w_idx];
  assign w_hi = EXP_TAB[w_nx];
  assign s_lo = ERFC_TAB[s_idx];
  assign s_hi = ERFC_TAB[s_nx];
  assign q_lo = ERFC_TAB[q_idx];
  assign q_hi = ERFC_TAB[q_nx];

endmodule
`default_nettype wire

>>> hdl/gamma_peak_shape_eval.sv
`default_nettype none
// Evaluates a Gaussian peak with smoothed step, linear background and skewed
// tail at one position per clock while req_stall is low; res_stall freezes the
// whole pipeline without loss once res_valid is high. Writing sigma or beta
// restarts the reciprocal unit (two 25-step divisions and one multiply),
// during which req_stall stays high. Exp and erfc come from constant
// interpolated tables built at elaboration.
module gamma_peak_shape_eval
  import gpse_pkg::*;
#(
  parameter int EXP_TABLE_DEPTH  = EXP_DEPTH_DEF,
  parameter int ERFC_TABLE_DEPTH = ERFC_DEPTH_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              wr_en,
  input  wire logic [CFG_IW-1:0] wr_index,
  input  wire logic [CFG_DW-1:0] wr_data,
  input  wire logic              req_valid,
  output logic                   req_stall,
  input  wire logic [23:0]       x_pos,
  output logic                   res_valid,
  input  wire logic              res_stall,
  output logic signed [47:0]     model_value,
  output logic                   saturated
);

  localparam int EXP_DW  = $clog2(EXP_TABLE_DEPTH + 1);
  localparam int ERFC_DW = $clog2(ERFC_TABLE_DEPTH + 1);
  localparam int EXP_PW  = 22 + EXP_DW;
  localparam int ERFC_PW = 20 + ERFC_DW;

  // ---------------- configuration
  logic [31:0] gauss_amp;
  logic [23:0] centroid;
  logic [15:0] sigma;
  logic [31:0] step_amp;
  logic [31:0] slope;
  logic [31:0] offset;
  logic [31:0] skew_amp;
  logic [15:0] beta;

  always_ff @(posedge clk) begin
    if (rst) begin
      gauss_amp <= '0;
      centroid  <= '0;
      sigma     <= 16'd256;
      step_amp  <= '0;
      slope     <= '0;
      offset    <= '0;
      skew_amp  <= '0;
      beta      <= 16'd256;
    end else if (wr_en) begin
      case (reg_idx_t'(wr_index))
        REG_GAUSS_AMP: gauss_amp <= wr_data;
        REG_CENTROID:  centroid  <= wr_data[23:0];
        REG_SIGMA:     sigma     <= wr_data[15:0];
        REG_STEP_AMP:  step_amp  <= wr_data;
        REG_SLOPE:     slope     <= wr_data;
        REG_OFFSET:    offset    <= wr_data;
        REG_SKEW_AMP:  skew_amp  <= wr_data;
        REG_BETA:      beta      <= wr_data[15:0];
        default: ;
      endcase
    end
  end

  recip_t rc;
  logic   recip_start;

  assign recip_start = wr_en && ((reg_idx_t'(wr_index) == REG_SIGMA) ||
                                 (reg_idx_t'(wr_index) == REG_BETA));

  gpse_recip u_recip (
    .clk   (clk),
    .rst   (rst),
    .start (recip_start),
    .sigma (sigma),
    .beta  (beta),
    .rc    (rc)
  );

  logic [31:0] mag_g;
  logic [31:0] mag_s;
  logic [31:0] mag_k;
  assign mag_g = gauss_amp[31] ? 32'(-gauss_amp) : gauss_amp;
  assign mag_s = step_amp[31] ? 32'(-step_amp) : step_amp;
  assign mag_k = skew_amp[31] ? 32'(-skew_amp) : skew_amp;

  // ---------------- pipeline control
  logic en;
  logic accept;
  logic v1, v2, v3, v4, v5, v6, v7, v8, v9;

  assign en        = !res_valid || !res_stall;
  assign req_stall = !en || rc.busy;
  assign accept    = req_valid && !req_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      {v1, v2, v3, v4, v5, v6, v7, v8, v9} <= '0;
      res_valid <= 1'b0;
    end else if (en) begin
      v1 <= accept;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
      v6 <= v5;
      v7 <= v6;
      v8 <= v7;
      v9 <= v8;
      res_valid <= v9;
    end
  end

  // ---------------- helpers
  function automatic logic [EXP_EW-1:0] lerp(input logic [EXP_EW-1:0] t0,
                                             input logic [EXP_EW-1:0] t1,
                                             input logic [15:0] f);
    logic [EXP_EW-1:0] d;
    logic [EXP_EW-1:0] hi;
    logic [31:0]       lo;
    logic [EXP_EW-1:0] m;
    d  = (t1 >= t0) ? t1 - t0 : t0 - t1;
    hi = {16'd0, d[55:16]} * {40'd0, f};
    lo = {16'd0, d[15:0]} * {16'd0, f};
    m  = hi + {40'd0, lo[31:16]};
    return (t1 >= t0) ? t0 + m : t0 - m;
  endfunction

  function automatic term_t sat_mag(input logic [63:0] r, input logic neg);
    term_t o;
    o.s = 1'b0;
    if (neg) begin
      if (r > (64'd1 << 47)) begin
        o.v = {1'b1, 47'd0};
        o.s = 1'b1;
      end else begin
        o.v = 48'(-r);
      end
    end else if (r > ((64'd1 << 47) - 64'd1)) begin
      o.v = {1'b0, {47{1'b1}}};
      o.s = 1'b1;
    end else begin
      o.v = r[47:0];
    end
    return o;
  endfunction

  // ---------------- stage 1: offsets from centroid, first products
  logic signed [24:0] u_c;
  assign u_c = $signed({1'b0, x_pos}) - $signed({1'b0, centroid});

  logic signed [56:0] pl1;
  logic signed [50:0] ps1;
  logic signed [50:0] pb1;

  always_ff @(posedge clk) begin
    if (en) begin
      pl1 <= $signed(slope) * $signed({1'b0, x_pos});
      ps1 <= u_c * $signed({1'b0, rc.inv_s});
      pb1 <= u_c * $signed({1'b0, rc.inv_b});
    end
  end

  // ---------------- stage 2: z, tail argument, background
  logic signed [50:0] z_c;
  logic signed [51:0] zq_c;
  logic signed [50:0] wb_c;
  logic signed [56:0] pl_sh;
  logic signed [20:0] zc2;
  logic signed [20:0] qc2;
  logic signed [21:0] w2;
  logic signed [41:0] lt2;

  assign z_c   = ps1 >>> 8;
  assign zq_c  = $signed({z_c[50], z_c}) + $signed({19'd0, rc.r});
  assign wb_c  = pb1 >>> 8;
  assign pl_sh = pl1 >>> 16;

  always_ff @(posedge clk) begin
    if (en) begin
      if (z_c > 51'sd524288) zc2 <= 21'sd524288;
      else if (z_c < -51'sd524288) zc2 <= -21'sd524288;
      else zc2 <= z_c[20:0];
      if (zq_c > 52'sd524288) qc2 <= 21'sd524288;
      else if (zq_c < -52'sd524288) qc2 <= -21'sd524288;
      else qc2 <= zq_c[20:0];
      if (wb_c > 51'sd1048576) w2 <= 22'sd1048576;
      else if (wb_c < -51'sd1048576) w2 <= -22'sd1048576;
      else w2 <= wb_c[21:0];
      lt2 <= $signed(pl_sh[41:0]) + $signed({{10{offset[31]}}, offset});
    end
  end

  // ---------------- stage 3: squares and scaling by 1/sqrt2
  logic signed [41:0] zsq3;
  logic signed [52:0] ps3;
  logic signed [52:0] pq3;
  logic signed [21:0] w3;
  logic signed [41:0] lt3;

  always_ff @(posedge clk) begin
    if (en) begin
      zsq3 <= zc2 * zc2;
      ps3  <= zc2 * INV_SQRT2_Q30;
      pq3  <= qc2 * INV_SQRT2_Q30;
      w3   <= w2;
      lt3  <= lt2;
    end
  end

  // ---------------- stage 4: clamp arguments, table index and fraction
  logic [24:0]        zs_c;
  logic [21:0]        goff;
  logic [21:0]        woff;
  logic signed [52:0] sa_c;
  logic signed [52:0] qa_c;
  logic [19:0]        soff;
  logic [19:0]        qoff;
  logic [EXP_PW-1:0]  gpos;
  logic [EXP_PW-1:0]  wpos;
  logic [ERFC_PW-1:0] spos;
  logic [ERFC_PW-1:0] qpos;

  assign zs_c = zsq3[41:17];
  assign goff = (zs_c > 25'd1048576) ? 22'd0 : 22'(25'd1048576 - zs_c);
  assign woff = 22'(w3 + 22'sd1048576);
  assign sa_c = ps3 >>> 30;
  assign qa_c = pq3 >>> 30;

  always_comb begin
    if (sa_c > 53'sd262144) soff = 20'd524288;
    else if (sa_c < -53'sd262144) soff = 20'd0;
    else soff = 20'(sa_c[19:0] + 20'd262144);
    if (qa_c > 53'sd262144) qoff = 20'd524288;
    else if (qa_c < -53'sd262144) qoff = 20'd0;
    else qoff = 20'(qa_c[19:0] + 20'd262144);
  end

  assign gpos = EXP_PW'(goff) * EXP_PW'(EXP_TABLE_DEPTH);
  assign wpos = EXP_PW'(woff) * EXP_PW'(EXP_TABLE_DEPTH);
  assign spos = ERFC_PW'(soff) * ERFC_PW'(ERFC_TABLE_DEPTH);
  assign qpos = ERFC_PW'(qoff) * ERFC_PW'(ERFC_TABLE_DEPTH);

  logic [EXP_DW-1:0]  gi4, wi4;
  logic [ERFC_DW-1:0] si4, qi4;
  logic [15:0]        gf4, wf4, sf4, qf4;
  logic signed [41:0] lt4;

  always_ff @(posedge clk) begin
    if (en) begin
      gi4 <= gpos[21+EXP_DW-1:21];
      wi4 <= wpos[21+EXP_DW-1:21];
      si4 <= spos[19+ERFC_DW-1:19];
      qi4 <= qpos[19+ERFC_DW-1:19];
      gf4 <= gpos[20:5];
      wf4 <= wpos[20:5];
      sf4 <= spos[18:3];
      qf4 <= qpos[18:3];
      lt4 <= lt3;
    end
  end

  // ---------------- stage 5: table reads
  logic [EXP_EW-1:0] g_lo, g_hi, w_lo, w_hi;
  logic [31:0]       s_lo, s_hi, q_lo, q_hi;

  gpse_lut #(
    .EXP_TABLE_DEPTH  (EXP_TABLE_DEPTH),
    .ERFC_TABLE_DEPTH (ERFC_TABLE_DEPTH),
    .EXP_DW           (EXP_DW),
    .ERFC_DW          (ERFC_DW)
  ) u_lut (
    .g_idx (gi4),
    .w_idx (wi4),
    .s_idx (si4),
    .q_idx (qi4),
    .g_lo  (g_lo),
    .g_hi  (g_hi),
    .w_lo  (w_lo),
    .w_hi  (w_hi),
    .s_lo  (s_lo),
    .s_hi  (s_hi),
    .q_lo  (q_lo),
    .q_hi  (q_hi)
  );

  logic [EXP_EW-1:0]  g0_5, g1_5, w0_5, w1_5;
  logic [31:0]        s0_5, s1_5, q0_5, q1_5;
  logic [15:0]        gf5, wf5, sf5, qf5;
  logic signed [41:0] lt5;

  always_ff @(posedge clk) begin
    if (en) begin
      g0_5 <= g_lo;
      g1_5 <= g_hi;
      w0_5 <= w_lo;
      w1_5 <= w_hi;
      s0_5 <= s_lo;
      s1_5 <= s_hi;
      q0_5 <= q_lo;
      q1_5 <= q_hi;
      gf5  <= gf4;
      wf5  <= wf4;
      sf5  <= sf4;
      qf5  <= qf4;
      lt5  <= lt4;
    end
  end

  // ---------------- stage 6: interpolation
  logic [EXP_EW-1:0]  ge6, ew6, sv6l, eq6l;
  logic [31:0]        sv6, eq6;
  logic signed [41:0] lt6;

  assign sv6l = lerp({24'd0, s0_5}, {24'd0, s1_5}, sf5);
  assign eq6l = lerp({24'd0, q0_5}, {24'd0, q1_5}, qf5);

  always_ff @(posedge clk) begin
    if (en) begin
      ge6 <= lerp(g0_5, g1_5, gf5);
      ew6 <= lerp(w0_5, w1_5, wf5);
      sv6 <= sv6l[31:0];
      eq6 <= eq6l[31:0];
      lt6 <= lt5;
    end
  end

  // ---------------- stage 7: amplitude products, tail shape product
  logic [55:0]        gph7;
  logic [63:0]        gpl7;
  logic [63:0]        spr7;
  logic [55:0]        pph7;
  logic [63:0]        ppl7;
  logic signed [41:0] lt7;

  always_ff @(posedge clk) begin
    if (en) begin
      gph7 <= {24'd0, mag_g} * {32'd0, ge6[55:32]};
      gpl7 <= {32'd0, mag_g} * {32'd0, ge6[31:0]};
      spr7 <= {32'd0, mag_s} * {32'd0, sv6};
      pph7 <= {32'd0, ew6[55:32]} * {24'd0, eq6};
      ppl7 <= {32'd0, ew6[31:0]} * {32'd0, eq6};
      lt7  <= lt6;
    end
  end

  // ---------------- stage 8: finish G and S, tail amplitude product
  logic [58:0] p8_c;
  term_t       gt8_c;
  term_t       st8_c;

  assign p8_c  = {1'b0, pph7, 2'b00} + {25'd0, ppl7[63:30]};
  assign gt8_c = sat_mag({8'd0, gph7} + {32'd0, gpl7[63:32]}, gauss_amp[31]);
  assign st8_c = sat_mag({30'd0, spr7[63:30]}, step_amp[31]);

  term_t              gt8;
  term_t              st8;
  logic [58:0]        kph8;
  logic [63:0]        kpl8;
  logic signed [41:0] lt8;

  always_ff @(posedge clk) begin
    if (en) begin
      gt8  <= gt8_c;
      st8  <= st8_c;
      kph8 <= {27'd0, mag_k} * {32'd0, p8_c[58:32]};
      kpl8 <= {32'd0, mag_k} * {32'd0, p8_c[31:0]};
      lt8  <= lt7;
    end
  end

  // ---------------- stage 9: finish K, sum and collect saturation flags
  term_t              kt9_c;
  logic signed [49:0] tot_c;

  assign kt9_c = sat_mag({5'd0, kph8} + {32'd0, kpl8[63:32]}, skew_amp[31]);
  assign tot_c = {{2{gt8.v[47]}}, gt8.v} + {{2{st8.v[47]}}, st8.v}
               + {{8{lt8[41]}}, lt8} + {{2{kt9_c.v[47]}}, kt9_c.v};

  logic signed [49:0] tot9;
  logic               sat9;

  always_ff @(posedge clk) begin
    if (en) begin
      tot9 <= tot_c;
      sat9 <= gt8.s || st8.s || kt9_c.s;
    end
  end

  // ---------------- output register
  always_ff @(posedge clk) begin
    if (en) begin
      if (tot9 > 50'sd140737488355327) begin
        model_value <= {1'b0, {47{1'b1}}};
        saturated   <= 1'b1;
      end else if (tot9 < -50'sd140737488355328) begin
        model_value <= {1'b1, 47'd0};
        saturated   <= 1'b1;
      end else begin
        model_value <= tot9[47:0];
        saturated   <= sat9;
      end
    end
  end

  a_no_take_while_busy: assert property (@(posedge clk) disable iff (rst)
    rc.busy |-> req_stall)
    else $error("request taken while reciprocals are stale");

  a_hold_valids: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable({v1, v2, v3, v4, v5, v6, v7, v8, v9}))
    else $error("pipeline moved during stall");

  a_last_stage_out: assert property (@(posedge clk) disable iff (rst)
    (v9 && en) |=> res_valid)
    else $error("result lost at output register");

endmodule
`default_nettype wire
